// ----- sv/tts_pkg.sv -----
// Shared types, constants and Q16.16 helpers for the tridiagonal solver.
// Used by every module of the block except tts_ram; depends on nothing.
package tts_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int ROW_W        = 6;
  localparam int DIV_STEPS    = 48;
  localparam int DIV_CNT_W    = 6;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // One row word as it travels from the front to the engine.
  typedef struct packed {
    q_t               diag;
    q_t               lower;
    q_t               upper;
    q_t               rhs;
    logic [ROW_W-1:0] idx;
    logic             first;
    logic             last;
  } tts_row_t;

  // One result word.
  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    q_t               solution;
    logic             pivot_error;
    logic             result_last;
  } tts_res_t;

  function automatic q_t sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return Q_MAX;
    end else if (v < -64'sd2147483648) begin
      return Q_MIN;
    end
    return q_t'(v[31:0]);
  endfunction

  // The arithmetic shift rounds toward minus infinity.
  function automatic q_t qmul_fix(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return sat_q(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [63:0] d;
    d = $signed({{32{a[31]}}, a}) - $signed({{32{b[31]}}, b});
    return sat_q(d);
  endfunction

endpackage

// ----- sv/tridiagonal_thomas_solver.sv -----
// Tridiagonal solver, Thomas algorithm, Q16.16. A row after the first passes
// through the 48-step serial divider in the engine (a first row skips it in the
// forward sweep); the front queue holds two rows meanwhile. After the last
// row is accepted, back substitution returns one result per divide, from the
// last row down to row zero, while the receiver keeps up.
// Synchronous active-low reset empties both queues and starts a new system.
module tridiagonal_thomas_solver import tts_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  q_t               in_diag_value,
  input  q_t               in_lower_value,
  input  q_t               in_upper_value,
  input  q_t               in_rhs_value,
  input  logic             in_row_last,
  output logic             empty,
  input  logic             pop,
  output logic [ROW_W-1:0] out_row_index,
  output q_t               out_solution_value,
  output logic             out_pivot_error,
  output logic             out_result_last
);

  logic     row_empty;
  logic     row_pop;
  tts_row_t row_head;
  logic     res_full;
  logic     res_push;
  tts_res_t res_word;
  tts_res_t head;

  tts_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_diag_value(in_diag_value), .in_lower_value(in_lower_value),
    .in_upper_value(in_upper_value), .in_rhs_value(in_rhs_value),
    .in_row_last(in_row_last), .row_pop(row_pop), .row_empty(row_empty),
    .row_head(row_head)
  );

  tts_engine #(.MAX_ROWS(MAX_ROWS)) u_engine (
    .clk(clk), .rst_n(rst_n), .row_empty(row_empty), .row_head(row_head),
    .row_pop(row_pop), .res_full(res_full), .res_push(res_push),
    .res_word(res_word)
  );

  tts_outq u_outq (
    .clk(clk), .rst_n(rst_n), .res_push(res_push), .res_word(res_word),
    .res_full(res_full), .pop(pop), .empty(empty), .head(head)
  );

  assign out_row_index      = head.row_index;
  assign out_solution_value = head.solution;
  assign out_pivot_error    = head.pivot_error;
  assign out_result_last    = head.result_last;

endmodule

// ----- sv/tts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tts_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- sv/tts_div.sv -----
// Radix-2 restoring divider for Q16.16 quotients with saturation.
// Depends on tts_pkg.
module tts_div import tts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  q_t   a,
  input  q_t   b,
  output logic done,
  output q_t   q
);

  logic [47:0]          dq_r;
  logic [32:0]          rem_r;
  logic [31:0]          d_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  logic                 run_r;
  logic                 done_r;
  q_t                   q_r;

  logic [32:0] t_nxt;
  logic        ge_nxt;
  logic [32:0] rem_nxt;
  logic [47:0] dq_nxt;
  logic [31:0] a_mag;
  logic [31:0] b_mag;
  q_t          sat_nxt;

  assign a_mag  = a[31] ? (~a + 32'd1) : a;
  assign b_mag  = b[31] ? (~b + 32'd1) : b;
  assign t_nxt  = {rem_r[31:0], dq_r[47]};
  assign ge_nxt = t_nxt >= {1'b0, d_r};
  assign rem_nxt = ge_nxt ? (t_nxt - {1'b0, d_r}) : t_nxt;
  assign dq_nxt = {dq_r[46:0], ge_nxt};

  always_comb begin
    if (!neg_r) begin
      sat_nxt = (dq_nxt > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(dq_nxt[31:0]);
    end else begin
      sat_nxt = (dq_nxt > 48'h0000_8000_0000) ? Q_MIN : q_t'(~dq_nxt[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (b == 32'sd0) begin
          // A zero divisor saturates by the sign of the numerator (zero for a zero numerator).
          q_r    <= (a > 32'sd0) ? Q_MAX : ((a < 32'sd0) ? Q_MIN : 32'sd0);
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end else begin
          dq_r  <= {a_mag, 16'h0000};
          rem_r <= '0;
          d_r   <= b_mag;
          neg_r <= a[31] ^ b[31];
          cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          q_r    <= sat_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- sv/tts_front.sv -----
// Input side: takes row words, marks first and last rows, and queues them.
// Depends on tts_pkg.
module tts_front import tts_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  q_t       in_diag_value,
  input  q_t       in_lower_value,
  input  q_t       in_upper_value,
  input  q_t       in_rhs_value,
  input  logic     in_row_last,
  input  logic     row_pop,
  output logic     row_empty,
  output tts_row_t row_head
);

  localparam int AW = $clog2(MAX_ROWS);

  tts_row_t      slot_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    fill_r;
  logic [AW-1:0] cnt_r;
  logic          acc;
  logic          last_nxt;
  tts_row_t      word_nxt;

  assign full      = fill_r == 2'd2;
  assign row_empty = fill_r == 2'd0;
  assign row_head  = slot_r[rp_r];
  assign acc       = push && !full;

  // A full store ends the system as if the row were flagged last.
  assign last_nxt = in_row_last || (cnt_r == AW'(MAX_ROWS - 1));

  always_comb begin
    word_nxt.diag  = in_diag_value;
    word_nxt.lower = in_lower_value;
    word_nxt.upper = in_upper_value;
    word_nxt.rhs   = in_rhs_value;
    word_nxt.idx   = ROW_W'(cnt_r);
    word_nxt.first = cnt_r == '0;
    word_nxt.last  = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r[wp_r] <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
      cnt_r  <= '0;
    end else begin
      if (acc) begin
        wp_r  <= ~wp_r;
        cnt_r <= last_nxt ? '0 : cnt_r + AW'(1);
      end
      if (row_pop && !row_empty) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + 2'(acc) - 2'(row_pop && !row_empty);
    end
  end

endmodule

// ----- sv/tts_outq.sv -----
// Two-word result queue between the engine and the result ports.
// Depends on tts_pkg.
module tts_outq import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  tts_res_t res_word,
  output logic     res_full,
  input  logic     pop,
  output logic     empty,
  output tts_res_t head
);

  tts_res_t   slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] fill_r;
  logic       acc;
  logic       take;

  assign res_full = fill_r == 2'd2;
  assign empty    = fill_r == 2'd0;
  assign head     = slot_r[rp_r];
  assign acc      = res_push && !res_full;
  assign take     = pop && !empty;

  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r[wp_r] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (acc) begin
        wp_r <= ~wp_r;
      end
      if (take) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + 2'(acc) - 2'(take);
    end
  end

endmodule

// ----- sv/tts_engine.sv -----
// Back part: forward elimination per row and back substitution per system.
// Depends on tts_pkg, tts_ram and tts_div.
module tts_engine import tts_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     row_empty,
  input  tts_row_t row_head,
  output logic     row_pop,
  input  logic     res_full,
  output logic     res_push,
  output tts_res_t res_word
);

  localparam int AW = $clog2(MAX_ROWS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FDIV = 4'd1;
  localparam logic [3:0] S_FM1  = 4'd2;
  localparam logic [3:0] S_FM2  = 4'd3;
  localparam logic [3:0] S_FM3  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_BDIV = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_BRD  = 4'd8;
  localparam logic [3:0] S_BM0  = 4'd9;
  localparam logic [3:0] S_BM1  = 4'd10;

  logic [3:0]         state_r;
  tts_row_t           cur_r;
  q_t                 prev_piv_r;
  q_t                 prev_up_r;
  q_t                 prev_rhs_r;
  q_t                 piv_new_r;
  q_t                 rhs_new_r;
  q_t                 w_r;
  q_t                 x_r;
  logic [ROW_W-1:0]   k_r;
  logic               err_r;
  logic signed [63:0] prod_r;

  q_t   mul_a;
  q_t   mul_b;
  logic div_start;
  q_t   div_a;
  q_t   div_b;
  logic div_done;
  q_t   div_q;
  logic we;
  q_t   rd_piv;
  q_t   rd_rhs;
  q_t   rd_up;
  q_t   bnum;

  tts_ram #(.W(32), .DEPTH(MAX_ROWS)) u_piv (
    .clk(clk), .we(we), .waddr(cur_r.idx[AW-1:0]), .wdata(piv_new_r),
    .raddr(k_r[AW-1:0]), .rdata(rd_piv)
  );
  tts_ram #(.W(32), .DEPTH(MAX_ROWS)) u_rhs (
    .clk(clk), .we(we), .waddr(cur_r.idx[AW-1:0]), .wdata(rhs_new_r),
    .raddr(k_r[AW-1:0]), .rdata(rd_rhs)
  );
  tts_ram #(.W(32), .DEPTH(MAX_ROWS)) u_up (
    .clk(clk), .we(we), .waddr(cur_r.idx[AW-1:0]), .wdata(cur_r.upper),
    .raddr(k_r[AW-1:0]), .rdata(rd_up)
  );

  tts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q)
  );

  assign bnum = qsub(rd_rhs, qmul_fix(prod_r));
  assign we   = state_r == S_WR;

  always_comb begin
    row_pop   = 1'b0;
    res_push  = 1'b0;
    div_start = 1'b0;
    div_a     = row_head.lower;
    div_b     = prev_piv_r;
    mul_a     = w_r;
    mul_b     = prev_up_r;
    unique case (state_r)
      S_IDLE: begin
        row_pop   = !row_empty;
        div_start = !row_empty && !row_head.first;
      end
      S_FM2: begin
        mul_b = prev_rhs_r;
      end
      S_WR: begin
        div_start = cur_r.last;
        div_a     = rhs_new_r;
        div_b     = piv_new_r;
      end
      S_EMIT: begin
        res_push = !res_full;
      end
      S_BM0: begin
        mul_a = rd_up;
        mul_b = x_r;
      end
      S_BM1: begin
        div_start = 1'b1;
        div_a     = bnum;
        div_b     = rd_piv;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_word.row_index   = k_r;
    res_word.solution    = x_r;
    res_word.pivot_error = err_r;
    res_word.result_last = k_r == '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (state_r == S_IDLE && !row_empty) begin
      cur_r     <= row_head;
      piv_new_r <= row_head.diag;
      rhs_new_r <= row_head.rhs;
    end
    if (state_r == S_FDIV && div_done) begin
      w_r <= div_q;
    end
    if (state_r == S_FM2) begin
      piv_new_r <= qsub(cur_r.diag, qmul_fix(prod_r));
    end
    if (state_r == S_FM3) begin
      rhs_new_r <= qsub(cur_r.rhs, qmul_fix(prod_r));
    end
    if (state_r == S_WR) begin
      prev_piv_r <= piv_new_r;
      prev_rhs_r <= rhs_new_r;
      prev_up_r  <= cur_r.upper;
    end
    if (state_r == S_BDIV && div_done) begin
      x_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      // Every pivot is divided by before the first result leaves.
      if (div_start && div_b == 32'sd0) begin
        err_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!row_empty) begin
            state_r <= row_head.first ? S_WR : S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            state_r <= S_FM1;
          end
        end
        S_FM1: state_r <= S_FM2;
        S_FM2: state_r <= S_FM3;
        S_FM3: state_r <= S_WR;
        S_WR: begin
          if (cur_r.last) begin
            k_r     <= cur_r.idx;
            state_r <= S_BDIV;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_BDIV: begin
          if (div_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            if (k_r == '0) begin
              err_r   <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r - ROW_W'(1);
              state_r <= S_BRD;
            end
          end
        end
        S_BRD: state_r <= S_BM0;
        S_BM0: state_r <= S_BM1;
        S_BM1: state_r <= S_BDIV;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/tts_checker.sv -----
// Port-level checks on the result stream of the solver, bound to the top.
// Depends on tts_pkg and tridiagonal_thomas_solver.
module tts_checker import tts_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             empty,
  input logic             pop,
  input logic [ROW_W-1:0] out_row_index,
  input q_t               out_solution_value,
  input logic             out_pivot_error,
  input logic             out_result_last
);

  // The index, solution and last flag of a waiting word hold until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !empty && !pop) |=> (!empty && $stable(out_row_index)
      && $stable(out_solution_value) && $stable(out_result_last)))
    else $error("result word changed while waiting");

  // The last word of a run is row zero, and only row zero is last.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_result_last == (out_row_index == '0)))
    else $error("result_last does not match row zero");

  // Results walk down one row at a time.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && pop && !empty && !out_result_last) ##1 !empty
      |-> out_row_index == $past(out_row_index) - ROW_W'(1))
    else $error("row index did not step down by one");

  // The error flag is the same on every word of a system.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && pop && !empty && !out_result_last) ##1 !empty
      |-> out_pivot_error == $past(out_pivot_error))
    else $error("pivot_error changed within a system");

endmodule

bind tridiagonal_thomas_solver tts_checker u_chk (.*);

// ----- tb/sv/tb_tridiagonal_thomas_solver.sv -----
// Testbench for the tridiagonal Thomas solver: directed rows, then random systems,
// with an in-bench Q16.16 predictor and a scoreboard. Depends on tts_pkg and the RTL.
`timescale 1ns / 100ps

module tb_tridiagonal_thomas_solver;
  import tts_pkg::*;

  localparam int  N_ITEMS = 430;
  localparam int  LIMIT   = 2000000;
  localparam q_t  ONE     = 32'sh0001_0000;

  typedef struct {
    q_t   diag;
    q_t   lower;
    q_t   upper;
    q_t   rhs;
    logic last;
    logic typed;
    q_t   exp_sol;
    logic exp_err;
  } row_word_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  logic             full;
  logic             empty;
  q_t               in_diag_value = '0;
  q_t               in_lower_value = '0;
  q_t               in_upper_value = '0;
  q_t               in_rhs_value = '0;
  logic             in_row_last = 1'b0;
  logic [ROW_W-1:0] out_row_index;
  q_t               out_solution_value;
  logic             out_pivot_error;
  logic             out_result_last;

  row_word_t rows[$];
  tts_res_t  solutions_due[$];
  int        n_directed;
  int        mismatches = 0;
  int        cycles = 0;
  bit        hold_req = 0;

  // Solver state kept by the predictor.
  q_t       piv_mem[64];
  q_t       rhs_mem[64];
  q_t       upr_mem[64];
  int       rows_taken = 0;
  bit       zero_pivot = 0;

  tridiagonal_thomas_solver dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_diag_value(in_diag_value), .in_lower_value(in_lower_value),
    .in_upper_value(in_upper_value), .in_rhs_value(in_rhs_value),
    .in_row_last(in_row_last), .empty(empty), .pop(pop),
    .out_row_index(out_row_index), .out_solution_value(out_solution_value),
    .out_pivot_error(out_pivot_error), .out_result_last(out_result_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic q_t clip(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return q_t'(v);
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip(p >>> 16);
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b);
    return clip(longint'(a) - longint'(b));
  endfunction

  function q_t fx_div(input q_t a, input q_t b);
    if (b == 0) begin
      zero_pivot = 1;
      if (a > 0) return 32'sh7FFF_FFFF;
      if (a < 0) return 32'sh8000_0000;
      return '0;
    end
    return clip((longint'(a) * 65536) / longint'(b));
  endfunction

  // Forward sweep on one row; on the final row, back substitution queues the solution.
  task automatic solve_row(input row_word_t w);
    int       r;
    int       first_due;
    q_t       m;
    q_t       x;
    tts_res_t res;
    r = rows_taken;
    if (r == 0) begin
      piv_mem[0] = w.diag;
      rhs_mem[0] = w.rhs;
    end else begin
      m = fx_div(w.lower, piv_mem[r-1]);
      piv_mem[r] = fx_sub(w.diag, fx_mul(m, upr_mem[r-1]));
      rhs_mem[r] = fx_sub(w.rhs, fx_mul(m, rhs_mem[r-1]));
    end
    upr_mem[r] = w.upper;
    if (!w.last && r + 1 < MAX_ROWS_DEF) begin
      rows_taken = r + 1;
      return;
    end
    first_due = solutions_due.size();
    x = fx_div(rhs_mem[r], piv_mem[r]);
    res.row_index = ROW_W'(r);
    res.solution = x;
    res.pivot_error = 0;
    res.result_last = (r == 0);
    solutions_due = {solutions_due, res};
    for (int k = r - 1; k >= 0; k--) begin
      x = fx_div(fx_sub(rhs_mem[k], fx_mul(upr_mem[k], x)), piv_mem[k]);
      res.row_index = ROW_W'(k);
      res.solution = x;
      res.result_last = (k == 0);
      solutions_due = {solutions_due, res};
    end
    for (int j = first_due; j < solutions_due.size(); j++)
      solutions_due[j].pivot_error = zero_pivot;
    // A single-row system with a typed answer overrides the computed one.
    if (w.typed) begin
      solutions_due[first_due].solution = w.exp_sol;
      solutions_due[first_due].pivot_error = w.exp_err;
    end
    rows_taken = 0;
    zero_pivot = 0;
  endtask

  task automatic add_row(input q_t d, input q_t l, input q_t u, input q_t r, input logic last,
                         input logic typed = 0, input q_t es = '0, input logic ee = 0);
    row_word_t w;
    w.diag = d;
    w.lower = l;
    w.upper = u;
    w.rhs = r;
    w.last = last;
    w.typed = typed;
    w.exp_sol = es;
    w.exp_err = ee;
    rows = {rows, w};
  endtask

  function automatic q_t any_word();
    return q_t'($urandom);
  endfunction

  function automatic q_t small_signed(input int span);
    return q_t'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  // One random system: mostly diagonally dominant, sometimes raw bits or zero diagonals.
  task automatic add_system();
    int  len;
    int  kind;
    bit  open_end;
    q_t  d;
    kind = $urandom_range(9, 0);
    len = ($urandom_range(19, 0) == 0) ? 64 : $urandom_range(6, 1);
    open_end = (len == 64) && $urandom_range(1, 0);
    for (int i = 0; i < len; i++) begin
      if (kind < 2) begin
        add_row(any_word(), any_word(), any_word(), any_word(),
                (i == len - 1) && !open_end);
      end else begin
        d = q_t'(($urandom_range(1, 0) ? 1 : -1) * int'($urandom_range(8 * ONE, 3 * ONE)));
        if (kind == 2 && $urandom_range(2, 0) == 0) d = '0;
        add_row(d, small_signed(ONE), small_signed(ONE), small_signed(1 << 22),
                (i == len - 1) && !open_end);
      end
    end
  endtask

  task automatic report(input string what, input tts_res_t got, input tts_res_t want);
    $display("MISMATCH %s: got row %0d x %h err %b last %b, want row %0d x %h err %b last %b",
             what, got.row_index, got.solution, got.pivot_error, got.result_last,
             want.row_index, want.solution, want.pivot_error, want.result_last);
    mismatches++;
  endtask

  // Receiver: bursts of pops and stalls, plus one long hold-off to fill the block.
  initial begin
    tts_res_t got;
    tts_res_t want;
    int       run_left;
    bit       pop_on;
    bit       held;
    run_left = 0;
    pop_on = 1;
    held = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.row_index = out_row_index;
        got.solution = out_solution_value;
        got.pivot_error = out_pivot_error;
        got.result_last = out_result_last;
        if (solutions_due.size() == 0) begin
          report("unexpected word", got, got);
        end else begin
          want = solutions_due.pop_front();
          if (got !== want) report("field", got, want);
        end
      end
      if (hold_req && !held) begin
        held = 1;
        pop <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if (run_left == 0) begin
        pop_on = !pop_on || ($urandom_range(3, 0) == 0);
        run_left = pop_on ? $urandom_range(40, 1) : $urandom_range(12, 1);
      end
      run_left--;
      pop <= pop_on;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int        sent;
    int        burst_left;
    int        gap_left;
    row_word_t w;

    // Single-row systems: plain, zero pivot with each numerator sign, extremes.
    add_row(ONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 3 * ONE, 1, 1, 3 * ONE, 0);
    add_row('0, '0, '0, 5, 1, 1, 32'sh7FFF_FFFF, 1);
    add_row('0, '0, '0, -5, 1, 1, 32'sh8000_0000, 1);
    add_row('0, '0, '0, '0, 1, 1, '0, 1);
    add_row(2 * ONE, '0, '0, 32'sh7FFF_FFFF, 1);
    add_row(-1, '0, '0, 32'sh8000_0000, 1);
    add_row(32'sh8000_0000, '0, '0, 32'sh7FFF_FFFF, 1);
    add_row(32'sh7FFF_FFFF, '0, '0, 32'sh8000_0000, 1);
    add_row(-1, '1, '1, '1, 1);
    // Three rows with extreme couplings; lower of row zero and upper of the last are ignored.
    add_row(4 * ONE, 32'sh8000_0000, 32'sh7FFF_FFFF, ONE, 0);
    add_row(4 * ONE, 32'sh8000_0000, ONE, 32'sh7FFF_FFFF, 0);
    add_row(-4 * ONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1);
    // Zero pivot on row zero flags every word of the system.
    add_row('0, '0, ONE, ONE, 0);
    add_row(2 * ONE, ONE, '0, ONE, 1);
    // Zero pivot in the middle.
    add_row(ONE, '0, ONE, 2 * ONE, 0);
    add_row(ONE, ONE, ONE, ONE, 0);
    add_row(3 * ONE, -ONE, '0, -ONE, 1);
    // A well-conditioned four-row system.
    add_row(4 * ONE, '0, ONE, ONE, 0);
    add_row(4 * ONE, ONE, ONE, 2 * ONE, 0);
    add_row(4 * ONE, ONE, ONE, 3 * ONE, 0);
    add_row(4 * ONE, ONE, '0, 4 * ONE, 1);
    n_directed = rows.size();
    while (rows.size() < N_ITEMS) add_system();
    // Close any open system so that nothing is left in the forward sweep.
    if (!rows[rows.size() - 1].last) rows[rows.size() - 1].last = 1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    sent = 0;
    burst_left = $urandom_range(20, 1);
    gap_left = 0;
    while (sent < rows.size()) begin
      @(posedge clk);
      if (push && !full) begin
        solve_row(rows[sent]);
        sent++;
        if (sent == n_directed) hold_req = 1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(30, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(80, 1);
        end
      end
      if (sent < rows.size()) begin
        w = rows[sent];
        in_diag_value <= w.diag;
        in_lower_value <= w.lower;
        in_upper_value <= w.upper;
        in_rhs_value <= w.rhs;
        in_row_last <= w.last;
      end
      push <= (gap_left == 0) && (sent < rows.size());
      if (gap_left > 0) gap_left--;
    end
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- tridiagonal_thomas_solver.f -----
sv/tts_pkg.sv
sv/tts_ram.sv
sv/tts_div.sv
sv/tts_front.sv
sv/tts_outq.sv
sv/tts_engine.sv
sv/tridiagonal_thomas_solver.sv
sv/tts_checker.sv
tb/sv/tb_tridiagonal_thomas_solver.sv
